@@ rtl/crsf_pkg.sv @@
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared constants, codes and the crc-8 dvb-s2 step for the crsf receiver.
// ----------------------------------------------------------------------------
package crsf_pkg;

    localparam int DEF_BUFFER_BYTES  = 64;
    localparam int DEF_CHANNEL_COUNT = 16;

    localparam logic [7:0] SYNC_BYTE  = 8'hC8;
    localparam logic [7:0] TYPE_RC    = 8'h16;
    localparam logic [7:0] TYPE_TELEM = 8'h2D;
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [5:0] MAX_OUT    = 6'd60;

    localparam logic [10:0] RST_OFFSET   = 11'd172;
    localparam logic [15:0] RST_GAIN     = 16'd19993;
    localparam logic [5:0]  RST_CAPACITY = 6'd60;

    // result kinds
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_TELEM   = 2'd1;
    localparam logic [1:0] KIND_NODELIV = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_OFFSET   = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/crsf_ram.sv @@
// ----------------------------------------------------------------------------
// crsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/crsf_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// Byte-wise crsf frame receiver: sync hunt, length check, crc-8 dvb-s2,
// rc channel unpack and scaling, telemetry payload forwarding.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)        | tuser    | tlast
//  s_*     | in        | rx_byte[7:0]              | gap_seen | -
//  m_*     | out       | index[5:0], value[23:6]   | kind     | last
//  cfg_*   | in        | cfg_data: offset/gain/capacity by cfg_index
//
// a byte that does not complete a frame leaves the receiver idle. a completed
// rc frame runs three buffer reads (read, capture), subtract, the shared
// multiplier and output load per channel; telemetry a read and an output state
// per payload byte, both bound by the single buffer read port. s_tready is low
// until the frame's results are all loaded; m_tready stalls hold the sequencer.
// reset clears fill count and control; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module crsf_frame_receiver
    import crsf_pkg::*;
#(
    parameter int BUFFER_BYTES  = DEF_BUFFER_BYTES,
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // gap_seen
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // index[5:0], value[23:6]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // last
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int XW = 10;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RC_RD, ST_RC_CAP, ST_RC_SUB, ST_RC_MUL, ST_RC_OUT,
        ST_TM_RD, ST_TM_OUT, ST_ND_OUT
    } state_t;

    logic [10:0] offset_reg;
    logic [15:0] gain_reg;
    logic [5:0]  cap_reg;

    state_t               state_reg, state_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           type_reg, type_next;
    logic [7:0]           crc_reg, crc_next;
    logic [CW-1:0]        ch_reg, ch_next;
    logic [7:0]           bitpos_reg, bitpos_next;
    logic [1:0]           k_reg, k_next;
    logic [23:0]          win_reg, win_next;
    logic signed [11:0]   diff_reg, diff_next;
    logic signed [28:0]   prod_reg, prod_next;
    logic [7:0]           pos_reg, pos_next;
    logic                 mvalid_reg, mvalid_next;
    logic [23:0]          mdata_reg, mdata_next;
    logic [1:0]           muser_reg, muser_next;
    logic                 mlast_reg, mlast_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    crsf_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RST_OFFSET;
            gain_reg   <= RST_GAIN;
            cap_reg    <= RST_CAPACITY;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_OFFSET:   offset_reg <= cfg_data[10:0];
                REG_GAIN:     gain_reg   <= cfg_data;
                REG_CAPACITY: cap_reg    <= cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    logic          out_free;
    logic          accept;
    logic [FW-1:0] fc;
    logic [XW-1:0] fc_x, len_x, plen_x, cap_x, rpos_x;
    logic [5:0]    cap_eff;
    logic [7:0]    plen;
    logic          rd_ok;
    logic [10:0]   raw;

    assign out_free = !mvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

    assign fc      = s_tuser ? '0 : fill_reg;
    assign fc_x    = XW'(fc);
    assign len_x   = XW'(len_reg);
    assign plen    = len_reg - 8'd2;
    assign plen_x  = XW'(plen);
    assign cap_eff = (cap_reg > MAX_OUT) ? MAX_OUT : cap_reg;
    assign cap_x   = XW'(cap_eff);
    // payload byte position of the current window byte
    assign rpos_x  = XW'(bitpos_reg[7:3]) + XW'(k_reg);
    assign rd_ok   = rpos_x < plen_x;
    assign raw     = 11'(win_reg >> bitpos_reg[2:0]);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        ch_next     = ch_reg;
        bitpos_next = bitpos_reg;
        k_next      = k_reg;
        win_next    = win_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        pos_next    = pos_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mlast_next  = mlast_reg;
        wr_en       = 1'b0;
        wr_addr     = fc[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = AW'(rpos_x + XW'(3));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fc;
                    if (fc == '0 && s_tdata != SYNC_BYTE)
                    begin
                        fill_next = '0;
                    end
                    else if (fc_x >= XW'(BUFFER_BYTES))
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        fill_next = fc + FW'(1);
                        if (fc_x == XW'(1))
                        begin
                            len_next = s_tdata;
                            if (s_tdata < 8'd2 ||
                                XW'(s_tdata) + XW'(2) > XW'(BUFFER_BYTES))
                                fill_next = '0;
                        end
                        if (fc_x == XW'(2))
                        begin
                            type_next = s_tdata;
                            crc_next  = crc_step(8'd0, s_tdata);
                        end
                        else if (fc_x >= XW'(3) && fc_x <= len_x)
                        begin
                            crc_next = crc_step(crc_reg, s_tdata);
                        end
                        if (fc_x >= XW'(3) && fc_x == len_x + XW'(1))
                        begin
                            // frame complete, s_tdata is the crc byte
                            fill_next   = '0;
                            ch_next     = '0;
                            bitpos_next = '0;
                            k_next      = '0;
                            pos_next    = '0;
                            if (crc_reg == s_tdata)
                            begin
                                if (type_reg == TYPE_RC)
                                    state_next = ST_RC_RD;
                                else if (type_reg == TYPE_TELEM)
                                begin
                                    if (plen_x > cap_x)
                                        state_next = ST_ND_OUT;
                                    else if (plen != 8'd0)
                                        state_next = ST_TM_RD;
                                end
                            end
                        end
                    end
                end
            end
            ST_RC_RD:
            begin
                rd_en      = rd_ok;
                state_next = ST_RC_CAP;
            end
            ST_RC_CAP:
            begin
                case (k_reg)
                    2'd0:    win_next[7:0]   = rd_ok ? rd_data : 8'd0;
                    2'd1:    win_next[15:8]  = rd_ok ? rd_data : 8'd0;
                    default: win_next[23:16] = rd_ok ? rd_data : 8'd0;
                endcase
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = ST_RC_SUB;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_RC_RD;
                end
            end
            ST_RC_SUB:
            begin
                diff_next  = $signed({1'b0, raw}) - $signed({1'b0, offset_reg});
                state_next = ST_RC_MUL;
            end
            ST_RC_MUL:
            begin
                prod_next  = 29'(diff_reg * $signed({1'b0, gain_reg}));
                state_next = ST_RC_OUT;
            end
            ST_RC_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = KIND_CHANNEL;
                    mdata_next  = {prod_reg[27:10], 6'(ch_reg)};
                    mlast_next  = (32'(ch_reg) == CHANNEL_COUNT - 1);
                    if (32'(ch_reg) == CHANNEL_COUNT - 1)
                        state_next = ST_IDLE;
                    else
                    begin
                        ch_next     = ch_reg + CW'(1);
                        bitpos_next = bitpos_reg + 8'd11;
                        state_next  = ST_RC_RD;
                    end
                end
            end
            ST_TM_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(XW'(pos_reg) + XW'(3));
                state_next = ST_TM_OUT;
            end
            ST_TM_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = KIND_TELEM;
                    mdata_next  = {10'd0, rd_data, pos_reg[5:0]};
                    mlast_next  = (pos_reg + 8'd1 == plen);
                    if (pos_reg + 8'd1 == plen)
                        state_next = ST_IDLE;
                    else
                    begin
                        pos_next   = pos_reg + 8'd1;
                        state_next = ST_TM_RD;
                    end
                end
            end
            ST_ND_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    muser_next  = KIND_NODELIV;
                    mdata_next  = '0;
                    mlast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            ch_reg     <= '0;
            k_reg      <= '0;
            pos_reg    <= '0;
            bitpos_reg <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            ch_reg     <= ch_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
            bitpos_reg <= bitpos_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        type_reg  <= type_next;
        crc_reg   <= crc_next;
        win_reg   <= win_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for crsf_frame_receiver: streams well-formed and broken
// crsf frames through the byte port under random gaps and output stalls,
// predicts channel and telemetry results and compares them beat by beat.
// ----------------------------------------------------------------------------
module tb_top;
    import crsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES  = 64;
    localparam int NUM_CHANNELS = 16;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         index;
        logic signed [17:0] value;
        logic               last;
    } crsf_result_t;

    class crsf_predictor;
        logic [7:0]   frame_bytes [FRAME_BYTES];
        int unsigned  fill;
        logic [10:0]  offset;
        logic [15:0]  gain;
        logic [5:0]   capacity;
        crsf_result_t pending_results[$];
        int           errors;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            fill     = 0;
            offset   = RST_OFFSET;
            gain     = RST_GAIN;
            capacity = RST_CAPACITY;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == REG_OFFSET)
                offset = data[10:0];
            else if (idx == REG_GAIN)
                gain = data;
            else if (idx == REG_CAPACITY)
                capacity = data[5:0];
        endfunction

        function logic [7:0] crc8(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        // payload bytes past the received length read as zero
        function logic [7:0] payload_at(int unsigned pos, int unsigned plen);
            if (pos >= plen || 3 + pos >= FRAME_BYTES)
                return 8'h00;
            return frame_bytes[3 + pos];
        endfunction

        function void push(logic [1:0] kind, int unsigned idx, logic signed [17:0] val,
                           logic last);
            crsf_result_t r;
            r.kind  = kind;
            r.index = idx[5:0];
            r.value = val;
            r.last  = last;
            pending_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic gap);
            int unsigned len;
            int unsigned plen;
            int unsigned cap;
            int unsigned bitpos;
            logic [7:0]  crc;
            logic [23:0] win;
            longint      raw;
            longint      prod;
            if (gap)
                fill = 0;
            if (fill == 0 && b != SYNC_BYTE)
                return;
            if (fill >= FRAME_BYTES)
            begin
                fill = 0;
                return;
            end
            frame_bytes[fill] = b;
            fill++;
            if (fill == 2)
            begin
                if (b < 2 || b + 2 > FRAME_BYTES)
                    fill = 0;
                return;
            end
            if (fill < 4)
                return;
            len = frame_bytes[1];
            if (fill < len + 2)
                return;
            fill = 0;
            crc  = 8'h00;
            for (int unsigned i = 0; i + 1 < len; i++)
                crc = crc8(crc, frame_bytes[2 + i]);
            if (crc != frame_bytes[len + 1])
                return;
            plen = len - 2;
            if (frame_bytes[2] == TYPE_RC)
            begin
                for (int unsigned i = 0; i < NUM_CHANNELS; i++)
                begin
                    bitpos = 11 * i;
                    win  = {payload_at((bitpos >> 3) + 2, plen),
                            payload_at((bitpos >> 3) + 1, plen),
                            payload_at(bitpos >> 3, plen)};
                    raw  = longint'((win >> (bitpos & 7)) & 24'h7FF);
                    prod = (raw - longint'(offset)) * longint'(gain);
                    push(KIND_CHANNEL, i, 18'(prod >>> 10), i + 1 == NUM_CHANNELS);
                end
            end
            else if (frame_bytes[2] == TYPE_TELEM)
            begin
                cap = (capacity > MAX_OUT) ? MAX_OUT : capacity;
                if (plen > cap)
                    push(KIND_NODELIV, 0, 18'sd0, 1'b1);
                else
                    for (int unsigned i = 0; i < plen; i++)
                        push(KIND_TELEM, i, 18'(frame_bytes[3 + i]), i + 1 == plen);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [5:0] idx,
                                   logic signed [17:0] val, logic last);
            crsf_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: kind %0d index %0d value %0d", kind, idx, val);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (idx !== e.index)
            begin
                $error("index: expected %0d, actual %0d", e.index, idx);
                errors++;
            end
            if (val !== e.value)
            begin
                $error("value: expected %0d, actual %0d", e.value, val);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte
    logic        s_tuser;   // gap_seen
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // index[5:0], value[23:6]
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    crsf_predictor predictor;
    int            cycles;
    int            burst_left;
    int            stall_mode;
    int            stall_left;
    int            bytes_sent;

    crsf_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: switches between always ready, random stalls and long stalls
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            predictor.check_result(m_tuser, m_tdata[5:0], m_tdata[23:6], m_tlast);
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic gap);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= gap;
        do
            @(posedge clk);
        while (!s_tready);
        predictor.note_byte(b, gap);
        bytes_sent++;
    endtask

    // flaw: 0 none, 1 bad crc, 2 gap inside, 3 bad length, 4 unknown type
    task automatic send_frame(input logic [7:0] ftype, input int plen, input int fill_mode,
                              input int flaw);
        logic [7:0] bytes[$];
        logic [7:0] crc;
        logic [7:0] badlen [4];
        int         gap_at;
        badlen = '{8'd0, 8'd1, 8'd63, 8'd255};
        bytes.push_back(SYNC_BYTE);
        bytes.push_back(8'(plen + 2));
        bytes.push_back(flaw == 4 ? 8'($urandom_range(0, 255)) : ftype);
        for (int i = 0; i < plen; i++)
            bytes.push_back(fill_mode == 1 ? 8'hFF : fill_mode == 2 ? 8'h00 :
                            8'($urandom_range(0, 255)));
        crc = 8'h00;
        for (int i = 2; i < bytes.size(); i++)
            crc = predictor.crc8(crc, bytes[i]);
        bytes.push_back(flaw == 1 ? crc ^ 8'($urandom_range(1, 255)) : crc);
        if (flaw == 3)
            bytes[1] = badlen[$urandom_range(0, 3)];
        gap_at = (flaw == 2) ? $urandom_range(1, bytes.size() - 1) : -1;
        foreach (bytes[i])
            send_byte(bytes[i], i == gap_at || (i == 0 && $urandom_range(0, 3) == 0));
    endtask

    task automatic wait_idle();
        // stop offering the last byte again while waiting
        s_tvalid <= 1'b0;
        while (predictor.pending_results.size() != 0)
            @(posedge clk);
        // a byte that makes no result can still be in flight
        repeat (40) @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] off, input logic [15:0] gn,
                                  input logic [15:0] cap);
        logic [15:0] vals [4];
        vals = '{off, gn, cap, 16'($urandom_range(0, 65535))};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            predictor.write_reg(2'(i), vals[i]);
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic random_traffic(input int nbytes);
        int sel;
        int target;
        target = bytes_sent + nbytes;
        while (bytes_sent < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)),
                                                        1'($urandom_range(0, 1)));
            else if (sel < 50)
                send_frame(TYPE_RC, $urandom_range(0, 3) == 0 ? $urandom_range(0, 22) : 22,
                           $urandom_range(0, 5) > 2 ? 0 : $urandom_range(0, 2),
                           $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4));
            else
                send_frame(TYPE_TELEM,
                           $urandom_range(0, 7) == 0 ? $urandom_range(0, 60)
                                                     : $urandom_range(0, 10),
                           0, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4));
        end
    endtask

    initial
    begin
        predictor  = new();
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        bytes_sent = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = REG_OFFSET;
        cfg_data   = 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, extreme channels, empty and oversize telemetry
        send_frame(TYPE_RC, 22, 1, 0);
        send_frame(TYPE_TELEM, 0, 0, 0);
        send_frame(TYPE_TELEM, 1, 1, 3);
        send_byte(8'h55, 1'b1);
        wait_idle();
        write_settings(16'd0, 16'hFFFF, 16'd0);
        send_frame(TYPE_RC, 22, 1, 0);
        send_frame(TYPE_TELEM, 1, 2, 0);
        wait_idle();
        write_settings(16'd2047, 16'hFFFF, 16'd63);
        send_frame(TYPE_RC, 22, 2, 0);
        send_frame(TYPE_RC, 3, 0, 0);
        wait_idle();

        // random phases, each ending with the sender held until all results are out
        random_traffic(20);
        wait_idle();
        write_settings(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 63)));
        random_traffic(20);
        wait_idle();
        write_settings(16'd2047, 16'd0, 16'd60);
        random_traffic(10);
        wait_idle();
        write_settings(16'd172, 16'd19993, 16'($urandom_range(0, 12)));
        random_traffic(20);
        wait_idle();
        if (predictor.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/crsf_pkg.sv
rtl/crsf_ram.sv
rtl/crsf_frame_receiver.sv
dv/tb_top.sv
